// ===== hw/rtl/single_source_shortest_paths_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the shortest path engine
// Concurrent property wrappers used by the engine's top module, the file that carries assertions.
// ----------------------------------------------------------------------------
`ifndef SINGLE_SOURCE_SHORTEST_PATHS_TOP_MACROS_SVH
`define SINGLE_SOURCE_SHORTEST_PATHS_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SSSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sssp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shortest path engine package
// Types, codes and constants shared by the engine's modules.
// ----------------------------------------------------------------------------
package sssp_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 256;

    localparam int VTX_W   = 6;
    localparam int WGT_W   = 16;
    localparam int VCNT_W  = 7;
    localparam int DIST_W  = 32;
    localparam int ODIST_W = 24;
    localparam int EDGE_W  = 2 * VTX_W + WGT_W;

    localparam logic [VCNT_W-1:0] VCOUNT_RESET = 7'd64;

    localparam logic signed [DIST_W-1:0] DIST_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DIST_W-1:0] DIST_MIN = 32'sh8000_0000;
    localparam logic signed [DIST_W-1:0] ODIST_MAX = 32'sd8388607;
    localparam logic signed [DIST_W-1:0] ODIST_MIN = -32'sd8388608;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_CLEAR = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        STAT_ACCEPTED = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_RANGE    = 3'd2,
        STAT_ROW      = 3'd3,
        STAT_NEGCYCLE = 3'd4,
        STAT_CLEARED  = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_EREAD,
        ST_EDEC,
        ST_DRD,
        ST_ADD,
        ST_CMP,
        ST_NEG,
        ST_OREAD,
        ST_OROW
    } t_state;

endpackage

// ===== hw/rtl/single_source_shortest_paths_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Single-source shortest path engine
// Edge table loader and Bellman-Ford relaxation sequencer with result rows.
// ----------------------------------------------------------------------------
// Add-edge and clear requests are accepted back to back while the output
// register drains. A run request occupies the engine until its last row is
// taken: the source is seeded first, then vertex_count passes go over the
// edge table (vertex_count-1 relaxing passes and one check pass). In a pass
// each edge is read and decoded; a skipped edge goes on to the next read,
// any other edge reads both distances, forms its candidate in the shared
// adder and compares it, and a last read closes the pass. The per-edge cost
// is set by the registered reads of the edge and distance RAMs and the single
// adder that forms the candidate and then compares it. Result rows follow,
// each vertex's entry read and then sent. A negative cycle found in the check
// pass ends the run with no result rows. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module single_source_shortest_paths_top #(
    parameter int MAX_VERTICES = sssp_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = sssp_pkg::MAX_EDGES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,   // vertex_count
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,     // from_vertex, to_vertex, weight, source_vertex, pad
    input  logic [1:0]  i_s_tuser,     // cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,     // vertex, distance, reachable, parent, has_parent, pad
    output logic [2:0]  o_m_tuser,     // status
    output logic        o_m_tlast
);

    `include "single_source_shortest_paths_top_macros.svh"

    localparam int VIDX_W = $clog2(MAX_VERTICES);
    localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECNT_W = $clog2(MAX_EDGES + 1);
    localparam int VW     = sssp_pkg::VTX_W;
    localparam int CW     = sssp_pkg::VCNT_W;
    localparam int DW     = sssp_pkg::DIST_W;
    localparam logic [CW-1:0]     VC_MAX    = CW'(MAX_VERTICES);
    localparam logic [ECNT_W-1:0] EDGES_MAX = ECNT_W'(MAX_EDGES);

    // Control registers
    sssp_pkg::t_state        r_state, n_state;
    logic [CW-1:0]           r_vcount, n_vcount;
    logic [ECNT_W-1:0]       r_edge_total, n_edge_total;
    logic [ECNT_W-1:0]       r_eidx, n_eidx;
    logic [CW-1:0]           r_pass, n_pass;
    logic [CW-1:0]           r_vidx, n_vidx;
    logic [MAX_VERTICES-1:0] r_reach, n_reach;
    logic [MAX_VERTICES-1:0] r_pok, n_pok;
    logic                    r_ovalid, n_ovalid;

    // Payload registers
    logic [VW-1:0]                      r_src, n_src;
    logic [VW-1:0]                      r_ea, n_ea;
    logic [VW-1:0]                      r_eb, n_eb;
    logic signed [sssp_pkg::WGT_W-1:0]  r_ew, n_ew;
    logic signed [DW-1:0]               r_cand, n_cand;
    sssp_pkg::t_status                  r_ostatus, n_ostatus;
    logic [VW-1:0]                      r_overtex, n_overtex;
    logic [sssp_pkg::ODIST_W-1:0]       r_odist, n_odist;
    logic                               r_oreach, n_oreach;
    logic [VW-1:0]                      r_oparent, n_oparent;
    logic                               r_ohp, n_ohp;
    logic                               r_olast, n_olast;

    // Input fields
    logic [1:0]                         w_cmd;
    logic [VW-1:0]                      w_fv, w_tv, w_sv;
    logic [sssp_pkg::WGT_W-1:0]         w_wgt;
    logic                               w_in_acc;
    logic                               w_oslot;
    logic [CW-1:0]                      w_vc;
    logic [CW-1:0]                      w_vc_m1;

    // Memory ports
    logic                               w_edge_we;
    logic [sssp_pkg::EDGE_W-1:0]        w_edge_rd;
    logic [VW-1:0]                      w_rd_a, w_rd_b;
    logic signed [sssp_pkg::WGT_W-1:0]  w_rd_w;
    logic                               w_dist_we;
    logic [VIDX_W-1:0]                  w_dist_waddr;
    logic [DW-1:0]                      w_dist_wdata;
    logic [VIDX_W-1:0]                  w_distb_raddr;
    logic [DW-1:0]                      w_da_raw, w_db_raw;
    logic signed [DW-1:0]               w_da, w_db;
    logic                               w_par_we;
    logic [VW-1:0]                      w_par_rd;

    // Shared adder
    logic                               w_alu_sub;
    logic signed [DW-1:0]               w_alu_x, w_alu_y;
    logic signed [DW-1:0]               w_alu_sat;
    logic                               w_alu_neg;

    logic                               w_relax;
    logic                               w_row_reach;
    logic signed [DW-1:0]               w_row_dist;

    assign w_cmd  = i_s_tuser;
    assign w_fv   = i_s_tdata[5:0];
    assign w_tv   = i_s_tdata[11:6];
    assign w_wgt  = i_s_tdata[27:12];
    assign w_sv   = i_s_tdata[33:28];

    assign w_oslot    = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == sssp_pkg::ST_IDLE) && w_oslot;
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    always_comb begin
        if (r_vcount == '0) begin
            w_vc = CW'(1);
        end else if (r_vcount > VC_MAX) begin
            w_vc = VC_MAX;
        end else begin
            w_vc = r_vcount;
        end
    end
    assign w_vc_m1 = w_vc - CW'(1);

    // Edge table: {weight, to, from}
    assign w_edge_we = w_in_acc && (w_cmd == sssp_pkg::CMD_ADD)
                    && ({1'b0, w_fv} < w_vc) && ({1'b0, w_tv} < w_vc)
                    && (r_edge_total < EDGES_MAX);

    sssp_ram #(
        .WIDTH (sssp_pkg::EDGE_W),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (w_edge_we),
        .i_waddr (r_edge_total[EIDX_W-1:0]),
        .i_wdata ({w_wgt, w_tv, w_fv}),
        .i_raddr (r_eidx[EIDX_W-1:0]),
        .o_rdata (w_edge_rd)
    );

    assign w_rd_a = w_edge_rd[VW-1:0];
    assign w_rd_b = w_edge_rd[2*VW-1:VW];
    assign w_rd_w = w_edge_rd[sssp_pkg::EDGE_W-1:2*VW];

    // Two copies of the distance store give the from and to reads together.
    assign w_distb_raddr = ((r_state == sssp_pkg::ST_OREAD) || (r_state == sssp_pkg::ST_OROW))
                         ? r_vidx[VIDX_W-1:0] : r_eb[VIDX_W-1:0];

    sssp_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_VERTICES)
    ) u_dist_a_ram (
        .i_clk   (i_clk),
        .i_we    (w_dist_we),
        .i_waddr (w_dist_waddr),
        .i_wdata (w_dist_wdata),
        .i_raddr (r_ea[VIDX_W-1:0]),
        .o_rdata (w_da_raw)
    );

    sssp_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_VERTICES)
    ) u_dist_b_ram (
        .i_clk   (i_clk),
        .i_we    (w_dist_we),
        .i_waddr (w_dist_waddr),
        .i_wdata (w_dist_wdata),
        .i_raddr (w_distb_raddr),
        .o_rdata (w_db_raw)
    );

    sssp_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (w_par_we),
        .i_waddr (r_eb[VIDX_W-1:0]),
        .i_wdata (r_ea),
        .i_raddr (r_vidx[VIDX_W-1:0]),
        .o_rdata (w_par_rd)
    );

    assign w_da = w_da_raw;
    assign w_db = w_db_raw;

    assign w_alu_sub = (r_state == sssp_pkg::ST_CMP);
    assign w_alu_x   = w_alu_sub ? r_cand : w_da;
    assign w_alu_y   = w_alu_sub ? w_db : DW'(r_ew);

    sssp_alu u_alu (
        .i_sub (w_alu_sub),
        .i_x   (w_alu_x),
        .i_y   (w_alu_y),
        .o_sat (w_alu_sat),
        .o_neg (w_alu_neg)
    );

    // Candidate beats the stored distance when cand - db is negative.
    assign w_relax   = !r_reach[r_eb[VIDX_W-1:0]] || w_alu_neg;
    assign w_dist_we = (r_state == sssp_pkg::ST_INIT)
                    || ((r_state == sssp_pkg::ST_CMP) && w_relax && (r_pass != w_vc_m1));
    assign w_par_we  = (r_state == sssp_pkg::ST_CMP) && w_relax && (r_pass != w_vc_m1);
    assign w_dist_waddr = (r_state == sssp_pkg::ST_INIT) ? r_src[VIDX_W-1:0]
                                                         : r_eb[VIDX_W-1:0];
    assign w_dist_wdata = (r_state == sssp_pkg::ST_INIT) ? '0 : r_cand;

    assign w_row_reach = r_reach[r_vidx[VIDX_W-1:0]];

    always_comb begin
        if (w_db > sssp_pkg::ODIST_MAX) begin
            w_row_dist = sssp_pkg::ODIST_MAX;
        end else if (w_db < sssp_pkg::ODIST_MIN) begin
            w_row_dist = sssp_pkg::ODIST_MIN;
        end else begin
            w_row_dist = w_db;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_vcount     = r_vcount;
        n_edge_total = r_edge_total;
        n_eidx       = r_eidx;
        n_pass       = r_pass;
        n_vidx       = r_vidx;
        n_reach      = r_reach;
        n_pok        = r_pok;
        n_ovalid     = r_ovalid && !i_m_tready;
        n_src        = r_src;
        n_ea         = r_ea;
        n_eb         = r_eb;
        n_ew         = r_ew;
        n_cand       = r_cand;
        n_ostatus    = r_ostatus;
        n_overtex    = r_overtex;
        n_odist      = r_odist;
        n_oreach     = r_oreach;
        n_oparent    = r_oparent;
        n_ohp        = r_ohp;
        n_olast      = r_olast;

        if (i_cfg_we) begin
            n_vcount = i_cfg_wdata;
        end

        case (r_state)
            sssp_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    // Single-result answers; fields other than status read zero.
                    n_overtex = '0;
                    n_odist   = '0;
                    n_oreach  = 1'b0;
                    n_oparent = '0;
                    n_ohp     = 1'b0;
                    n_olast   = 1'b1;
                    case (w_cmd)
                        sssp_pkg::CMD_ADD: begin
                            n_ovalid = 1'b1;
                            if (({1'b0, w_fv} >= w_vc) || ({1'b0, w_tv} >= w_vc)) begin
                                n_ostatus = sssp_pkg::STAT_RANGE;
                            end else if (r_edge_total >= EDGES_MAX) begin
                                n_ostatus = sssp_pkg::STAT_FULL;
                            end else begin
                                n_ostatus    = sssp_pkg::STAT_ACCEPTED;
                                n_edge_total = r_edge_total + ECNT_W'(1);
                            end
                        end
                        sssp_pkg::CMD_CLEAR: begin
                            n_ovalid     = 1'b1;
                            n_ostatus    = sssp_pkg::STAT_CLEARED;
                            n_edge_total = '0;
                        end
                        sssp_pkg::CMD_RUN: begin
                            if ({1'b0, w_sv} >= w_vc) begin
                                n_ovalid  = 1'b1;
                                n_ostatus = sssp_pkg::STAT_RANGE;
                            end else begin
                                n_src   = w_sv;
                                n_reach = '0;
                                n_reach[w_sv[VIDX_W-1:0]] = 1'b1;
                                n_pok   = '0;
                                n_pass  = '0;
                                n_eidx  = '0;
                                n_state = sssp_pkg::ST_INIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            sssp_pkg::ST_INIT: begin
                n_state = sssp_pkg::ST_EREAD;
            end
            sssp_pkg::ST_EREAD: begin
                if (r_eidx == r_edge_total) begin
                    n_eidx = '0;
                    if (r_pass == w_vc_m1) begin
                        n_vidx  = '0;
                        n_state = sssp_pkg::ST_OREAD;
                    end else begin
                        n_pass = r_pass + CW'(1);
                    end
                end else begin
                    n_state = sssp_pkg::ST_EDEC;
                end
            end
            sssp_pkg::ST_EDEC: begin
                n_ea = w_rd_a;
                n_eb = w_rd_b;
                n_ew = w_rd_w;
                // Stale edges and edges out of unreached vertices are skipped.
                if (({1'b0, w_rd_a} >= w_vc) || ({1'b0, w_rd_b} >= w_vc)
                        || !r_reach[w_rd_a[VIDX_W-1:0]]) begin
                    n_eidx  = r_eidx + ECNT_W'(1);
                    n_state = sssp_pkg::ST_EREAD;
                end else begin
                    n_state = sssp_pkg::ST_DRD;
                end
            end
            sssp_pkg::ST_DRD: begin
                n_state = sssp_pkg::ST_ADD;
            end
            sssp_pkg::ST_ADD: begin
                n_cand  = w_alu_sat;
                n_state = sssp_pkg::ST_CMP;
            end
            sssp_pkg::ST_CMP: begin
                n_eidx  = r_eidx + ECNT_W'(1);
                n_state = sssp_pkg::ST_EREAD;
                if (w_relax) begin
                    if (r_pass == w_vc_m1) begin
                        n_state = sssp_pkg::ST_NEG;
                    end else begin
                        n_reach[r_eb[VIDX_W-1:0]] = 1'b1;
                        n_pok[r_eb[VIDX_W-1:0]]   = 1'b1;
                    end
                end
            end
            sssp_pkg::ST_NEG: begin
                if (w_oslot) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = sssp_pkg::STAT_NEGCYCLE;
                    n_overtex = '0;
                    n_odist   = '0;
                    n_oreach  = 1'b0;
                    n_oparent = '0;
                    n_ohp     = 1'b0;
                    n_olast   = 1'b1;
                    n_state   = sssp_pkg::ST_IDLE;
                end
            end
            sssp_pkg::ST_OREAD: begin
                n_state = sssp_pkg::ST_OROW;
            end
            sssp_pkg::ST_OROW: begin
                if (w_oslot) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = sssp_pkg::STAT_ROW;
                    n_overtex = r_vidx[VW-1:0];
                    n_odist   = w_row_reach ? w_row_dist[sssp_pkg::ODIST_W-1:0] : '0;
                    n_oreach  = w_row_reach;
                    n_ohp     = w_row_reach && r_pok[r_vidx[VIDX_W-1:0]];
                    n_oparent = (w_row_reach && r_pok[r_vidx[VIDX_W-1:0]]) ? w_par_rd : '0;
                    n_olast   = (r_vidx == w_vc_m1);
                    if (r_vidx == w_vc_m1) begin
                        n_state = sssp_pkg::ST_IDLE;
                    end else begin
                        n_vidx  = r_vidx + CW'(1);
                        n_state = sssp_pkg::ST_OREAD;
                    end
                end
            end
            default: begin
                n_state = sssp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sssp_pkg::ST_IDLE;
            r_vcount     <= sssp_pkg::VCOUNT_RESET;
            r_edge_total <= '0;
            r_eidx       <= '0;
            r_pass       <= '0;
            r_vidx       <= '0;
            r_reach      <= '0;
            r_pok        <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_vcount     <= n_vcount;
            r_edge_total <= n_edge_total;
            r_eidx       <= n_eidx;
            r_pass       <= n_pass;
            r_vidx       <= n_vidx;
            r_reach      <= n_reach;
            r_pok        <= n_pok;
            r_ovalid     <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src     <= n_src;
        r_ea      <= n_ea;
        r_eb      <= n_eb;
        r_ew      <= n_ew;
        r_cand    <= n_cand;
        r_ostatus <= n_ostatus;
        r_overtex <= n_overtex;
        r_odist   <= n_odist;
        r_oreach  <= n_oreach;
        r_oparent <= n_oparent;
        r_ohp     <= n_ohp;
        r_olast   <= n_olast;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_ostatus;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {2'b00, r_ohp, r_oparent, r_oreach, r_odist, r_overtex};

    `SSSP_ASSERT_NOW(a_busy_not_ready, i_clk, i_rst_n,
        r_state != sssp_pkg::ST_IDLE, !o_s_tready,
        "engine accepts a request while a run is in progress")
    `SSSP_ASSERT_NOW(a_edge_total_bound, i_clk, i_rst_n,
        1'b1, r_edge_total <= EDGES_MAX,
        "edge count exceeds the table size")
    `SSSP_ASSERT_NOW(a_source_reached, i_clk, i_rst_n,
        r_state == sssp_pkg::ST_EREAD, r_reach[r_src[VIDX_W-1:0]],
        "source vertex lost its reachable mark during relaxation")
    `SSSP_ASSERT_NEXT(a_row_ends_run, i_clk, i_rst_n,
        (r_state == sssp_pkg::ST_OROW) && w_oslot && (r_vidx == w_vc_m1),
        (r_state == sssp_pkg::ST_IDLE) && o_m_tlast && o_m_tvalid,
        "final vertex row did not close the run")

endmodule

// ===== hw/rtl/sssp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module sssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/sssp_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared relaxation adder
// One 33-bit adder: saturating add for candidate distances, subtract for the
// distance compare.
// ----------------------------------------------------------------------------
module sssp_alu (
    input  logic                                i_sub,
    input  logic signed [sssp_pkg::DIST_W-1:0]  i_x,
    input  logic signed [sssp_pkg::DIST_W-1:0]  i_y,
    output logic signed [sssp_pkg::DIST_W-1:0]  o_sat,
    output logic                                o_neg
);

    logic [sssp_pkg::DIST_W:0] w_ye;
    logic [sssp_pkg::DIST_W:0] w_sum;

    always_comb begin
        w_ye  = i_sub ? ~{i_y[sssp_pkg::DIST_W-1], i_y} : {i_y[sssp_pkg::DIST_W-1], i_y};
        w_sum = {i_x[sssp_pkg::DIST_W-1], i_x} + w_ye
              + {{sssp_pkg::DIST_W{1'b0}}, i_sub};
        o_neg = w_sum[sssp_pkg::DIST_W];
        // A carry into the extra bit that disagrees with the top bit is overflow.
        if (w_sum[sssp_pkg::DIST_W] != w_sum[sssp_pkg::DIST_W-1]) begin
            o_sat = w_sum[sssp_pkg::DIST_W] ? sssp_pkg::DIST_MIN : sssp_pkg::DIST_MAX;
        end else begin
            o_sat = w_sum[sssp_pkg::DIST_W-1:0];
        end
    end

endmodule
